### rtl/core/sbst_pkg.sv
`default_nettype none

package sbst_pkg;

  // per-stage load enables handed to the cross-multiply comparators
  typedef struct packed {
    logic c;  // partial product stage
    logic d;  // product sum stage
  } stage_en_t;

endpackage

`default_nettype wire

### rtl/core/sbst_frac_le.sv
`default_nettype none

// exact a <= b for fractions sign/mag over a positive denominator
// two register stages: split partial products, then summed products
// le is combinational from the summed products
module sbst_frac_le #(
  parameter int MAG_BITS = 32
) (
  input  wire                     clk,
  input  wire sbst_pkg::stage_en_t en,
  input  wire                     a_neg,
  input  wire  [MAG_BITS-1:0]     a_mag,
  input  wire  [MAG_BITS-1:0]     a_den,
  input  wire                     b_neg,
  input  wire  [MAG_BITS-1:0]     b_mag,
  input  wire  [MAG_BITS-1:0]     b_den,
  output logic                    le
);
  import sbst_pkg::*;

  localparam int LO = (MAG_BITS + 1) / 2;
  localparam int HI = MAG_BITS - LO;
  localparam int PW = 2 * MAG_BITS;

  // p = |a.num| * b.den, q = |b.num| * a.den
  logic [2*LO-1:0]  p_ll_r, q_ll_r;
  logic [LO+HI-1:0] p_lh_r, p_hl_r, q_lh_r, q_hl_r;
  logic [2*HI-1:0]  p_hh_r, q_hh_r;
  logic             a_neg_c_r, b_neg_c_r;

  logic [PW-1:0]    p_r, q_r;
  logic             a_neg_d_r, b_neg_d_r;

  logic [PW-1:0]    p_nxt, q_nxt;

  always_ff @(posedge clk) begin
    if (en.c) begin
      p_ll_r    <= a_mag[LO-1:0] * b_den[LO-1:0];
      p_lh_r    <= a_mag[LO-1:0] * b_den[MAG_BITS-1:LO];
      p_hl_r    <= a_mag[MAG_BITS-1:LO] * b_den[LO-1:0];
      p_hh_r    <= a_mag[MAG_BITS-1:LO] * b_den[MAG_BITS-1:LO];
      q_ll_r    <= b_mag[LO-1:0] * a_den[LO-1:0];
      q_lh_r    <= b_mag[LO-1:0] * a_den[MAG_BITS-1:LO];
      q_hl_r    <= b_mag[MAG_BITS-1:LO] * a_den[LO-1:0];
      q_hh_r    <= b_mag[MAG_BITS-1:LO] * a_den[MAG_BITS-1:LO];
      a_neg_c_r <= a_neg;
      b_neg_c_r <= b_neg;
    end
  end

  always_comb begin
    p_nxt = PW'(p_ll_r) + (PW'(p_lh_r) << LO) + (PW'(p_hl_r) << LO)
          + (PW'(p_hh_r) << (2 * LO));
    q_nxt = PW'(q_ll_r) + (PW'(q_lh_r) << LO) + (PW'(q_hl_r) << LO)
          + (PW'(q_hh_r) << (2 * LO));
  end

  always_ff @(posedge clk) begin
    if (en.d) begin
      p_r       <= p_nxt;
      q_r       <= q_nxt;
      a_neg_d_r <= a_neg_c_r;
      b_neg_d_r <= b_neg_c_r;
    end
  end

  // signs differ: decided by sign; both negative: larger magnitude is smaller
  always_comb begin
    if (a_neg_d_r != b_neg_d_r) begin
      le = a_neg_d_r;
    end else if (a_neg_d_r) begin
      le = (p_r >= q_r);
    end else begin
      le = (p_r <= q_r);
    end
  end

endmodule

`default_nettype wire

### rtl/core/segment_box_slab_test_2d_unit.sv
`default_nettype none

// result runs through stages a to e and shows on out_*; throughput: one
//   transaction per cycle unless out_tready stalls; five register stages,
//   each with its own valid bit, so a bubble anywhere lets a new one in
// the deepest stages are the split cross-multiply comparators
// reset: rst_n synchronous active low, clears the valid bits only
module segment_box_slab_test_2d_unit #(
  parameter int COORD_BITS = 32
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // slave side: one segment and one box per transaction
  input  wire                        in_tvalid,
  output logic                       in_tready,
  // from bit 0 up: start_x, start_z, end_x, end_z,
  //   box_min_x, box_min_z, box_max_x, box_max_z
  input  wire  [8*COORD_BITS-1:0]    in_tdata,
  // master side: hit flag
  output logic                       out_tvalid,
  input  wire                        out_tready,
  // from bit 0 up: hit, then seven zero bits
  output logic [7:0]                 out_tdata
);
  import sbst_pkg::*;

  localparam int W = COORD_BITS;

  // one axis after direction folding: t interval [lo, hi] over den
  typedef struct packed {
    logic         act;   // direction not zero on this axis
    logic         lneg;
    logic [W-1:0] lmag;
    logic         hneg;
    logic [W-1:0] hmag;
    logic [W-1:0] den;
  } slab_t;

  // ---------------------------------------------------------------------------
  // handshake: each stage loads when empty or when the next one loads
  // ---------------------------------------------------------------------------
  logic      va_r, vb_r, vc_r, vd_r;
  logic      en_a, en_b, en_c, en_d, en_e;
  stage_en_t cmp_en;

  always_comb begin
    en_e      = !out_tvalid || out_tready;
    en_d      = !vd_r || en_e;
    en_c      = !vc_r || en_d;
    en_b      = !vb_r || en_c;
    en_a      = !va_r || en_b;
    // nothing is taken while reset is held
    in_tready = en_a && rst_n;
    cmp_en.c  = en_c;
    cmp_en.d  = en_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r       <= 1'b0;
      vb_r       <= 1'b0;
      vc_r       <= 1'b0;
      vd_r       <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      if (en_a) va_r <= in_tvalid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
      if (en_d) vd_r <= vc_r;
      if (en_e) out_tvalid <= vd_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: directions, plane offsets, parallel slab tests
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] sx, sz, ex, ez, mnx, mnz, mxx, mxz;
  logic signed [W:0]   dx_nxt, dz_nxt, n1x_nxt, n2x_nxt, n1z_nxt, n2z_nxt;
  logic                ok_a_nxt;

  logic signed [W:0]   dx_r, dz_r, n1x_r, n2x_r, n1z_r, n2z_r;
  logic                ok_a_r;

  always_comb begin
    sx  = in_tdata[0*W +: W];
    sz  = in_tdata[1*W +: W];
    ex  = in_tdata[2*W +: W];
    ez  = in_tdata[3*W +: W];
    mnx = in_tdata[4*W +: W];
    mnz = in_tdata[5*W +: W];
    mxx = in_tdata[6*W +: W];
    mxz = in_tdata[7*W +: W];

    dx_nxt  = (W+1)'(ex)  - (W+1)'(sx);
    dz_nxt  = (W+1)'(ez)  - (W+1)'(sz);
    n1x_nxt = (W+1)'(mnx) - (W+1)'(sx);
    n2x_nxt = (W+1)'(mxx) - (W+1)'(sx);
    n1z_nxt = (W+1)'(mnz) - (W+1)'(sz);
    n2z_nxt = (W+1)'(mxz) - (W+1)'(sz);

    // zero-length segment never hits; a parallel axis needs start inside
    ok_a_nxt = !(dx_nxt == '0 && dz_nxt == '0)
             && (dx_nxt != '0 || (sx >= mnx && sx <= mxx))
             && (dz_nxt != '0 || (sz >= mnz && sz <= mxz));
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      dx_r   <= dx_nxt;
      dz_r   <= dz_nxt;
      n1x_r  <= n1x_nxt;
      n2x_r  <= n2x_nxt;
      n1z_r  <= n1z_nxt;
      n2z_r  <= n2z_nxt;
      ok_a_r <= ok_a_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: fold the direction sign into the offsets, order entry and exit
  // ---------------------------------------------------------------------------
  function automatic slab_t slab_prep(input logic signed [W:0] d,
                                      input logic signed [W:0] n1,
                                      input logic signed [W:0] n2);
    logic              dneg;
    logic              pick1;
    logic signed [W:0] lraw, hraw;
    logic [W:0]        labs, habs, dabs;
    slab_t             s;
    dneg  = d[W];
    // with a negative direction both offsets flip sign, so the order swaps
    pick1 = (n1 < n2) ^ dneg;
    lraw  = pick1 ? n1 : n2;
    hraw  = pick1 ? n2 : n1;
    labs  = lraw[W] ? (W+1)'(-lraw) : (W+1)'(lraw);
    habs  = hraw[W] ? (W+1)'(-hraw) : (W+1)'(hraw);
    dabs  = dneg ? (W+1)'(-d) : (W+1)'(d);
    s.act  = (d != '0);
    s.lneg = dneg ? (!lraw[W] && lraw != '0) : lraw[W];
    s.hneg = dneg ? (!hraw[W] && hraw != '0) : hraw[W];
    s.lmag = labs[W-1:0];
    s.hmag = habs[W-1:0];
    s.den  = dabs[W-1:0];
    return s;
  endfunction

  slab_t sx_r, sz_r;
  logic  ok_b_r;

  always_ff @(posedge clk) begin
    if (en_b) begin
      sx_r   <= slab_prep(dx_r, n1x_r, n2x_r);
      sz_r   <= slab_prep(dz_r, n1z_r, n2z_r);
      ok_b_r <= ok_a_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: each active slab against [0, 1]; cross terms go to comparators
  // ---------------------------------------------------------------------------
  logic ok_x, ok_z;
  logic ok_c_r, both_c_r;
  logic ok_d_r, both_d_r;

  always_comb begin
    // exit >= 0 and entry <= 1 (entry num <= den)
    ok_x = !sx_r.act || (!sx_r.hneg && (sx_r.lneg || sx_r.lmag <= sx_r.den));
    ok_z = !sz_r.act || (!sz_r.hneg && (sz_r.lneg || sz_r.lmag <= sz_r.den));
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      ok_c_r   <= ok_b_r && ok_x && ok_z;
      both_c_r <= sx_r.act && sz_r.act;
    end
  end

  // entry x <= exit z
  logic le_xz;
  sbst_frac_le #(.MAG_BITS(W)) u_le_xz (
    .clk   (clk),
    .en    (cmp_en),
    .a_neg (sx_r.lneg),
    .a_mag (sx_r.lmag),
    .a_den (sx_r.den),
    .b_neg (sz_r.hneg),
    .b_mag (sz_r.hmag),
    .b_den (sz_r.den),
    .le    (le_xz)
  );

  // entry z <= exit x
  logic le_zx;
  sbst_frac_le #(.MAG_BITS(W)) u_le_zx (
    .clk   (clk),
    .en    (cmp_en),
    .a_neg (sz_r.lneg),
    .a_mag (sz_r.lmag),
    .a_den (sz_r.den),
    .b_neg (sx_r.hneg),
    .b_mag (sx_r.hmag),
    .b_den (sx_r.den),
    .le    (le_zx)
  );

  // ---------------------------------------------------------------------------
  // stage d: flags ride alongside the product sums
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en_d) begin
      ok_d_r   <= ok_c_r;
      both_d_r <= both_c_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage e: output register, the slabs must overlap when both are active
  // ---------------------------------------------------------------------------
  logic hit_r;

  always_ff @(posedge clk) begin
    if (en_e) begin
      hit_r <= ok_d_r && (!both_d_r || (le_xz && le_zx));
    end
  end

  assign out_tdata = {7'b0, hit_r};

endmodule

`default_nettype wire

### dv/tb_segment_box_slab_test_2d_unit.sv
module tb_segment_box_slab_test_2d_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS  = 32;
  localparam int Q           = 65536;              // 1.0 in Q16.16
  localparam int C_MIN       = -2147483647 - 1;
  localparam int C_MAX       = 2147483647;
  localparam int N_RANDOM    = 1700;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE      = 16;
  localparam int LIMIT_NS    = 4000000;

  // one segment and one box; declared high field first so that start_x
  // sits in the low bits once the struct is laid onto in_tdata
  typedef struct packed {
    logic signed [COORD_BITS-1:0] box_max_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] end_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] start_x;
  } seg_box_t;

  // wide enough for a 34-bit by 34-bit cross product with room to spare
  typedef logic signed [95:0] wide_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  // from bit 0 up: start_x, start_z, end_x, end_z,
  //   box_min_x, box_min_z, box_max_x, box_max_z
  logic [8*COORD_BITS-1:0] in_tdata   = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // from bit 0 up: hit, seven zero bits
  logic [7:0]              out_tdata;

  segment_box_slab_test_2d_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  seg_box_t    seg_box_q[$];     // segments still to be offered
  bit          hit_expect_q[$];  // predicted hit flags, oldest first
  int unsigned total_items  = 0;
  int unsigned accepted_in  = 0;
  int unsigned fail_count   = 0;
  bit          in_taken     = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned hold_cycles  = 0;
  int unsigned holds_done   = 0;
  int unsigned rx_cycle     = 0;
  int unsigned rx_left      = 0;
  rx_mode_e    rx_mode      = RX_FREE;

  // ---------------------------------------------------------------------
  // hit prediction: every t is kept as numerator over positive denominator
  // and compared by cross-multiplying, so no rounding enters anywhere
  // ---------------------------------------------------------------------

  // t interval of one slab; a zero direction gives no interval, only an
  // inside test on the start coordinate (bounds included)
  function automatic void slab_axis(input wide_t s, d, bmin, bmax,
                                    output bit in_slab, output bit active,
                                    output wide_t lo, hi, den);
    wide_t n1, n2;
    n1      = bmin - s;
    n2      = bmax - s;
    den     = d;
    lo      = '0;
    hi      = '0;
    active  = (d != 0);
    in_slab = 1'b1;
    if (d == 0) begin
      in_slab = (s >= bmin) && (s <= bmax);
    end else begin
      if (d < 0) begin
        n1  = -n1;
        n2  = -n2;
        den = -d;
      end
      // planes are unordered, so swapped corners behave like ordered ones
      lo = (n1 < n2) ? n1 : n2;
      hi = (n1 < n2) ? n2 : n1;
    end
  endfunction

  function automatic bit slab_hit(seg_box_t it);
    wide_t sx, sz, dx, dz;
    wide_t lo_x, hi_x, den_x, lo_z, hi_z, den_z;
    bit    in_x, in_z, act_x, act_z;
    sx = it.start_x;
    sz = it.start_z;
    dx = it.end_x - sx;
    dz = it.end_z - sz;
    // a point-sized segment never hits
    if (dx == 0 && dz == 0) return 1'b0;
    slab_axis(sx, dx, it.box_min_x, it.box_max_x, in_x, act_x, lo_x, hi_x, den_x);
    slab_axis(sz, dz, it.box_min_z, it.box_max_z, in_z, act_z, lo_z, hi_z, den_z);
    if (!in_x || !in_z) return 1'b0;
    // each slab interval must meet [0, 1]
    if (act_x && (hi_x < 0 || lo_x > den_x)) return 1'b0;
    if (act_z && (hi_z < 0 || lo_z > den_z)) return 1'b0;
    // and the two slabs must meet each other; touching counts
    if (act_x && act_z &&
        (lo_x * den_z > hi_z * den_x || lo_z * den_x > hi_x * den_z)) return 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  task automatic push_case(int sx, int sz, int ex, int ez,
                           int mnx, int mnz, int mxx, int mxz);
    seg_box_t it;
    it.start_x   = sx;
    it.start_z   = sz;
    it.end_x     = ex;
    it.end_z     = ez;
    it.box_min_x = mnx;
    it.box_min_z = mnz;
    it.box_max_x = mxx;
    it.box_max_z = mxz;
    seg_box_q.push_back(it);
  endtask

  function automatic int span_rand(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return int'($urandom);
    endcase
  endfunction

  // mostly segments placed around a box so that hits, grazes and parallel
  // runs all turn up; the rest is raw noise over the full field range
  function automatic seg_box_t random_item();
    seg_box_t    it;
    int          scale, lo_x, hi_x, lo_z, hi_z, px, pz, t;
    int unsigned kind;
    bit          on_x;
    kind  = $urandom_range(0, 99);
    // a few units usually, a handful of lsbs sometimes so exact ties are common
    scale = ($urandom_range(0, 3) == 0) ? 8 : 8 * Q;
    lo_x  = span_rand(scale);
    hi_x  = lo_x + int'($urandom_range(0, scale));
    lo_z  = span_rand(scale);
    hi_z  = lo_z + int'($urandom_range(0, scale));
    it.box_min_x = lo_x;
    it.box_max_x = hi_x;
    it.box_min_z = lo_z;
    it.box_max_z = hi_z;
    it.start_x   = span_rand(2 * scale);
    it.start_z   = span_rand(2 * scale);
    it.end_x     = span_rand(2 * scale);
    it.end_z     = span_rand(2 * scale);
    if (kind < 35) begin
      // free segment near the box, corners swapped now and then
      if ($urandom_range(0, 9) == 0) begin
        it.box_min_x = hi_x;
        it.box_max_x = lo_x;
      end
      if ($urandom_range(0, 9) == 0) begin
        it.box_min_z = hi_z;
        it.box_max_z = lo_z;
      end
    end else if (kind < 55) begin
      // one end pinned to a corner or a face of the box
      px = $urandom_range(0, 1) ? lo_x : hi_x;
      pz = $urandom_range(0, 1) ? lo_z : hi_z;
      case ($urandom_range(0, 2))
        0:       ;
        1:       px = lo_x + int'($urandom_range(0, hi_x - lo_x));
        default: pz = lo_z + int'($urandom_range(0, hi_z - lo_z));
      endcase
      if ($urandom_range(0, 1)) begin
        it.end_x = px;
        it.end_z = pz;
      end else begin
        it.start_x = px;
        it.start_z = pz;
      end
    end else if (kind < 70) begin
      // runs parallel to one axis, start on a plane, just off one, or anywhere
      on_x = $urandom_range(0, 1);
      case ($urandom_range(0, 4))
        0:       t = on_x ? lo_x : lo_z;
        1:       t = on_x ? hi_x : hi_z;
        2:       t = (on_x ? lo_x : lo_z) - 1;
        3:       t = (on_x ? hi_x : hi_z) + 1;
        default: t = span_rand(2 * scale);
      endcase
      if (on_x) begin
        it.start_x = t;
        it.end_x   = t;
      end else begin
        it.start_z = t;
        it.end_z   = t;
      end
      if ($urandom_range(0, 7) == 0) begin
        it.box_min_x = hi_x;
        it.box_max_x = lo_x;
        it.box_min_z = hi_z;
        it.box_max_z = lo_z;
      end
    end else if (kind < 75) begin
      // zero length
      it.end_x = it.start_x;
      it.end_z = it.start_z;
    end else if (kind < 90) begin
      it = {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
    end else begin
      it = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
            pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
    end
    return it;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reset, item list and end of run
  initial begin
    // zero-length segments: inside a box, at both range ends, outside
    push_case(Q, Q, Q, Q, 0, 0, 2*Q, 2*Q);
    push_case(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX);
    push_case(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX);
    push_case(5*Q, 5*Q, 5*Q, 5*Q, 0, 0, 2*Q, 2*Q);
    // plain diagonal through the box, both directions
    push_case(-Q, -Q, 3*Q, 3*Q, 0, 0, 2*Q, 2*Q);
    push_case(3*Q, 3*Q, -Q, -Q, 0, 0, 2*Q, 2*Q);
    // parallel to x: start z outside, inside, on the bound
    push_case(-Q, 3*Q, 3*Q, 3*Q, 0, 0, 2*Q, 2*Q);
    push_case(-Q, Q, 3*Q, Q, 0, 0, 2*Q, 2*Q);
    push_case(-Q, 2*Q, 3*Q, 2*Q, 0, 0, 2*Q, 2*Q);
    // parallel to z: inside, outside, on the bound
    push_case(Q, -Q, Q, 3*Q, 0, 0, 2*Q, 2*Q);
    push_case(3*Q, -Q, 3*Q, 3*Q, 0, 0, 2*Q, 2*Q);
    push_case(2*Q, -Q, 2*Q, 3*Q, 0, 0, 2*Q, 2*Q);
    // swapped corners: parallel axis misses, slanted one still hits
    push_case(Q, -Q, Q, 3*Q, 2*Q, 0, 0, 2*Q);
    push_case(-Q, -Q, 3*Q, 3*Q, 2*Q, 2*Q, 0, 0);
    // touching: end on a corner, line through a corner, one lsb off
    push_case(-2*Q, 0, 0, 2*Q, 0, 0, 2*Q, 2*Q);
    push_case(-Q, Q, Q, 3*Q, 0, 0, 2*Q, 2*Q);
    push_case(-Q, Q + 1, Q, 3*Q + 1, 0, 0, 2*Q, 2*Q);
    // segment stops short of the box, or starts past it
    push_case(-3*Q, -3*Q, -Q, -Q, 0, 0, 2*Q, 2*Q);
    push_case(3*Q, 3*Q, 5*Q, 5*Q, 0, 0, 2*Q, 2*Q);
    // point-sized box on and off the segment
    push_case(0, 0, 2*Q, 2*Q, Q, Q, Q, Q);
    push_case(0, 0, 2*Q, 2*Q, Q, Q + 1, Q, Q + 1);
    // full-range extremes
    push_case(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX);
    push_case(C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, Q, Q);
    push_case(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    push_case(Q, 3*Q, Q + 1, -Q, 0, 0, 2*Q, 2*Q);
    repeat (N_RANDOM) seg_box_q.push_back(random_item());
    total_items = seg_box_q.size();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // everything offered and taken, every prediction answered
    while (accepted_in != total_items || hit_expect_q.size() != 0) @(negedge clk);
    // a settle period to catch stray results
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // sender: bursts of random length with random gaps; valid is only moved
  // once the current transaction has gone through
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : feed
    logic     valid_nx;
    seg_box_t data_nx;
    valid_nx = in_tvalid;
    data_nx  = in_tdata;
    if (rst_n && (!in_tvalid || in_taken)) begin
      valid_nx = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (seg_box_q.size() > 0) begin
        valid_nx = 1'b1;
        data_nx  = seg_box_q.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // long unbroken stretches now and then
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_tvalid <= valid_nx;
    in_tdata  <= data_nx;
  end

  // ---------------------------------------------------------------------
  // receiver: switches between free running, random, a fixed pattern and
  // sparse acceptance; the hold-off below overrides all of them
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : drain
    logic rdy;
    rx_cycle++;
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:    rdy = 1'b1;
      RX_RANDOM:  rdy = ($urandom_range(0, 3) != 0);
      RX_PATTERN: rdy = ((rx_cycle % 7) < 3);
      default:    rdy = ($urandom_range(0, 5) == 0);
    endcase
    out_tready <= rdy && (hold_cycles == 0);
  end

  // long hold-off, twice in the run, while the sender keeps offering, so
  // the pipeline fills up and has to drop in_tready
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (holds_done < 2 && accepted_in >= 400 + 800 * holds_done) begin
      hold_cycles <= 300;
      holds_done  <= holds_done + 1;
    end
  end

  // ---------------------------------------------------------------------
  // both handshakes in one process: the result is checked before the new
  // prediction is queued, so ordering within the edge is fixed
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : score
    bit exp_hit;
    if (out_tvalid && out_tready) begin
      if (hit_expect_q.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: result with nothing expected, got %02h", $realtime, out_tdata);
        fail_count++;
      end else begin
        exp_hit = hit_expect_q.pop_front();
        // hit flag, and the padding above it must stay zero
        if (out_tdata[0] !== exp_hit || out_tdata[7:1] !== 7'd0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: hit mismatch, expected %02h got %02h",
                     $realtime, {7'd0, exp_hit}, out_tdata);
          fail_count++;
        end
      end
    end
    in_taken <= in_tvalid && in_tready;
    if (in_tvalid && in_tready) begin
      hit_expect_q.push_back(slab_hit(seg_box_t'(in_tdata)));
      accepted_in++;
    end
  end

endmodule

### filelist.f
rtl/core/sbst_pkg.sv
rtl/core/sbst_frac_le.sv
rtl/core/segment_box_slab_test_2d_unit.sv
dv/tb_segment_box_slab_test_2d_unit.sv
